// ===== rtl/rrc_pkg.sv =====
// Shared types and constants for the road roughness classifier.
package rrc_pkg;

  localparam int CFG_W     = 16;
  localparam int REG_IDX_W = 2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_BASELINE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_POTHOLE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROUGH    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_HOLD     = 2'd3;

  localparam logic [CFG_W-1:0] BASELINE_RST = 16'd8192;
  localparam logic [CFG_W-1:0] POTHOLE_RST  = 16'd4915;
  localparam logic [CFG_W-1:0] ROUGH_RST    = 16'd1229;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd1000;

  // item kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_EVAL   = 2'd2;

  // road status codes
  localparam logic [1:0] STATUS_NORMAL  = 2'd0;
  localparam logic [1:0] STATUS_ROUGH   = 2'd1;
  localparam logic [1:0] STATUS_POTHOLE = 2'd2;

  // last step of the fixed-length phases
  localparam int SQ_LAST   = 3;
  localparam int ROOT_LAST = 15;
  localparam logic [31:0] ROOT_BIT0 = 32'h4000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_SQUARE,
    ST_ROOT,
    ST_DEV,
    ST_APPLY,
    ST_WALK,
    ST_DIV,
    ST_JUDGE,
    ST_FINISH
  } rrc_state_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic sq;
    logic root;
    logic dev;
    logic apply;
    logic walk;
    logic div;
    logic judge;
    logic publish;
  } rrc_cmd_t;

  typedef struct packed {
    logic sq_last;
    logic root_last;
    logic walk_last;
    logic div_last;
  } rrc_stat_t;

endpackage

// ===== rtl/rrc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rrc_datapath.sv =====
// Datapath: config registers, magnitude, deviation ring, window statistics, result register.
module rrc_datapath #(
  parameter int WINDOW = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rrc_pkg::rrc_cmd_t             cmd,
  output rrc_pkg::rrc_stat_t            stat,
  input  logic                          cfg_write,
  input  logic [rrc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [rrc_pkg::CFG_W-1:0]     cfg_data,
  input  logic signed [15:0]            accel_x,
  input  logic signed [15:0]            accel_y,
  input  logic signed [15:0]            accel_z,
  output logic [1:0]                    road_status,
  output logic [15:0]                   pothole_total,
  output logic [15:0]                   window_peak,
  output logic [15:0]                   window_mean
);
  import rrc_pkg::*;

  localparam int AW        = $clog2(WINDOW);
  localparam int SUM_W     = 16 + $clog2(WINDOW);
  localparam int STEP_MAX  = (WINDOW + 1 > SUM_W) ? WINDOW + 1 : SUM_W;
  localparam int STEP_W    = $clog2(STEP_MAX + 1);
  // floor(sum / WINDOW) as (sum * RECIP) >> DIV_SHIFT, exact for any SUM_W-bit sum
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;

  localparam logic [SUM_W-1:0]   WIN_SUM  = SUM_W'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW);
  localparam logic [AW-1:0]      LAST_POS = AW'(WINDOW - 1);
  localparam logic [STEP_W-1:0]  WALK_END = STEP_W'(WINDOW);
  localparam logic [STEP_W-1:0]  DIV_END  = STEP_W'(0);
  localparam logic [STEP_W-1:0]  SQ_END   = STEP_W'(SQ_LAST);
  localparam logic [STEP_W-1:0]  ROOT_END = STEP_W'(ROOT_LAST);

  // configuration
  logic [15:0] baseline_level, pothole_level, rough_level, hold_time;

  // captured sample and magnitude pipeline
  logic signed [15:0] ax, ay, az;
  logic [STEP_W-1:0]  step;
  logic [31:0]        prod, acc, rem_v, root, bitv;
  logic [15:0]        mag, dev;

  // ring and window statistics
  logic [AW-1:0]      pos;
  logic [WINDOW-1:0]  ring_valid;
  logic               rd_valid;
  logic [15:0]        rd_data;
  logic [AW-1:0]      raddr;
  logic [SUM_W-1:0]   sum, sum_next, rough_sum;
  logic [PROD_W-1:0]  mean_prod;
  logic [15:0]        mean_q;
  logic [15:0]        peak, entry;

  // classifier state
  logic [1:0]  status_reg;
  logic [15:0] hold_remaining, pothole_counter, peak_latch, mean_latch;

  logic signed [15:0] sel;
  logic signed [31:0] sq_full;
  logic [31:0]        root_try, root_next;
  logic               root_ge, phase_end;

  assign stat.sq_last   = (step == SQ_END);
  assign stat.root_last = (step == ROOT_END);
  assign stat.walk_last = (step == WALK_END);
  assign stat.div_last  = (step == DIV_END);

  assign phase_end = (cmd.sq && stat.sq_last) || (cmd.root && stat.root_last) ||
                     (cmd.walk && stat.walk_last) || (cmd.div && stat.div_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_level <= BASELINE_RST;
      pothole_level  <= POTHOLE_RST;
      rough_level    <= ROUGH_RST;
      hold_time      <= HOLD_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASELINE: baseline_level <= cfg_data;
        REG_POTHOLE:  pothole_level  <= cfg_data;
        REG_ROUGH:    rough_level    <= cfg_data;
        REG_HOLD:     hold_time      <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.load || phase_end) begin
      step <= '0;
    end else if (cmd.sq || cmd.root || cmd.walk || cmd.div) begin
      step <= step + 1'b1;
    end
  end

  // sum of squares, one axis per step through a single multiplier
  always_comb begin
    case (step[1:0])
      2'd0:    sel = ax;
      2'd1:    sel = ay;
      default: sel = az;
    endcase
  end
  assign sq_full = sel * sel;

  // one result bit per step of the square root
  assign root_try  = root + bitv;
  assign root_ge   = (rem_v >= root_try);
  assign root_next = root_ge ? ((root >> 1) + bitv) : (root >> 1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax  <= accel_x;
      ay  <= accel_y;
      az  <= accel_z;
      acc <= '0;
    end
    if (cmd.sq) begin
      prod <= unsigned'(sq_full);
      if (step != '0) begin
        acc <= acc + prod;
      end
      if (stat.sq_last) begin
        rem_v <= acc + prod;
        root  <= '0;
        bitv  <= ROOT_BIT0;
      end
    end
    if (cmd.root) begin
      if (root_ge) begin
        rem_v <= rem_v - root_try;
      end
      root <= root_next;
      bitv <= bitv >> 2;
      if (stat.root_last) begin
        mag <= root_next[15:0];
      end
    end
    if (cmd.dev) begin
      dev <= (mag >= baseline_level) ? (mag - baseline_level) : (baseline_level - mag);
    end
  end

  // ring; never-written slots read as zero through their valid bit
  assign raddr = (step < WALK_END) ? step[AW-1:0] : '0;

  rrc_ram #(
    .WIDTH(16),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.apply),
    .waddr(pos),
    .wdata(dev),
    .raddr(raddr),
    .rdata(rd_data)
  );

  assign entry     = rd_valid ? rd_data : '0;
  assign sum_next  = sum + SUM_W'(entry);
  assign mean_prod = PROD_W'(sum) * PROD_W'(RECIP);
  assign rough_sum = SUM_W'(rough_level) * WIN_SUM;

  always_ff @(posedge clk) begin
    rd_valid <= ring_valid[raddr];
    if (cmd.walk) begin
      if (step == '0) begin
        sum  <= '0;
        peak <= '0;
      end else begin
        sum <= sum_next;
        if (entry > peak) begin
          peak <= entry;
        end
      end
    end
    if (cmd.div) begin
      mean_q <= mean_prod[DIV_SHIFT +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos             <= '0;
      ring_valid      <= '0;
      status_reg      <= STATUS_NORMAL;
      hold_remaining  <= '0;
      pothole_counter <= '0;
      peak_latch      <= '0;
      mean_latch      <= '0;
    end else begin
      if (cmd.tick && hold_remaining != '0) begin
        hold_remaining <= hold_remaining - 1'b1;
      end
      if (cmd.apply) begin
        ring_valid[pos] <= 1'b1;
        pos <= (pos == LAST_POS) ? '0 : pos + 1'b1;
        if (dev >= pothole_level) begin
          // count on entry only, saturate at full scale
          if (status_reg != STATUS_POTHOLE && pothole_counter != 16'hFFFF) begin
            pothole_counter <= pothole_counter + 1'b1;
          end
          status_reg     <= STATUS_POTHOLE;
          hold_remaining <= hold_time;
        end
      end
      if (cmd.judge) begin
        peak_latch <= peak;
        mean_latch <= mean_q;
        if (hold_remaining != '0) begin
          status_reg <= STATUS_POTHOLE;
        end else if (sum >= rough_sum) begin
          status_reg <= STATUS_ROUGH;
        end else begin
          status_reg <= STATUS_NORMAL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      road_status   <= status_reg;
      pothole_total <= pothole_counter;
      window_peak   <= peak_latch;
      window_mean   <= mean_latch;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= LAST_POS)
    else $error("ring position past window");

  a_hold_pothole: assert property (@(posedge clk) disable iff (rst)
    hold_remaining != '0 |-> status_reg == STATUS_POTHOLE)
    else $error("hold running without pothole status");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    pothole_counter == 16'hFFFF |=> pothole_counter == 16'hFFFF)
    else $error("pothole counter wrapped");
`endif

endmodule

// ===== rtl/rrc_ctrl.sv =====
// Controller: sequences each transaction through the datapath phases.
module rrc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  output logic               out_valid,
  input  logic               out_ready,
  output rrc_pkg::rrc_cmd_t  cmd,
  input  rrc_pkg::rrc_stat_t stat
);
  import rrc_pkg::*;

  rrc_state_t state, state_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (kind)
            KIND_TICK:   state_next = ST_TICK;
            KIND_SAMPLE: state_next = ST_SQUARE;
            KIND_EVAL:   state_next = ST_WALK;
            default:     state_next = ST_FINISH;
          endcase
        end
      end
      ST_TICK:   state_next = ST_FINISH;
      ST_SQUARE: if (stat.sq_last) state_next = ST_ROOT;
      ST_ROOT:   if (stat.root_last) state_next = ST_DEV;
      ST_DEV:    state_next = ST_APPLY;
      ST_APPLY:  state_next = ST_FINISH;
      ST_WALK:   if (stat.walk_last) state_next = ST_DIV;
      ST_DIV:    if (stat.div_last) state_next = ST_JUDGE;
      ST_JUDGE:  state_next = ST_FINISH;
      ST_FINISH: if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = (state == ST_IDLE);
    cmd.load = (state == ST_IDLE) && in_valid;
    unique case (state)
      ST_TICK:   cmd.tick    = 1'b1;
      ST_SQUARE: cmd.sq      = 1'b1;
      ST_ROOT:   cmd.root    = 1'b1;
      ST_DEV:    cmd.dev     = 1'b1;
      ST_APPLY:  cmd.apply   = 1'b1;
      ST_WALK:   cmd.walk    = 1'b1;
      ST_DIV:    cmd.div     = 1'b1;
      ST_JUDGE:  cmd.judge   = 1'b1;
      ST_FINISH: cmd.publish = slot_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_sample_root: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_SAMPLE |-> ##5 state == ST_ROOT)
    else $error("sample did not reach square root after four squaring steps");

  a_tick_finish: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_TICK |-> ##2 state == ST_FINISH)
    else $error("tick did not finish in two cycles");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && out_valid && !out_ready |=> state == ST_FINISH)
    else $error("new result published over a waiting one");
`endif

endmodule

// ===== rtl/road_roughness_classifier.sv =====
// Top level of the road roughness classifier: controller plus datapath.
//
// Input channel (in_valid/in_ready) carries one item: kind selects a 1 ms
// tick, an accelerometer sample (accel_x/y/z) or a window evaluation.
// Every item yields exactly one transaction on the output channel
// (out_valid/out_ready): road status, pothole count, window peak and mean.
// Items are processed one at a time; in_ready is high only when idle.
// From accept to result valid, a sample passes through 4 squaring steps on one
// 16x16 multiplier, 16 square-root steps, deviation, ring write and publish;
// an evaluation through a ring walk over the RAM read port, one reciprocal
// multiply for the mean, classification and publish. in_ready rises in the
// same cycle as out_valid.
// A finished result sits in the output register; the block takes the next
// item while it waits, and holds the following result until out_ready.
// Synchronous reset restores the configuration defaults, clears the ring
// (per-slot valid bits, no sweep), counters and status, and drops out_valid.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once; the
// user must only make them while the block is idle, as the block does not check.
module road_roughness_classifier #(
  parameter int WINDOW = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rrc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [rrc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic signed [15:0]            accel_x,
  input  logic signed [15:0]            accel_y,
  input  logic signed [15:0]            accel_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    road_status,
  output logic [15:0]                   pothole_total,
  output logic [15:0]                   window_peak,
  output logic [15:0]                   window_mean
);
  import rrc_pkg::*;

  rrc_cmd_t  cmd;
  rrc_stat_t stat;

  rrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  rrc_datapath #(
    .WINDOW(WINDOW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .road_status  (road_status),
    .pothole_total(pothole_total),
    .window_peak  (window_peak),
    .window_mean  (window_mean)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for road_roughness_classifier with a built-in road status predictor.
module tb;
  import rrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
  } road_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] total;
    logic [15:0] peak;
    logic [15:0] mean;
  } road_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic signed [15:0] accel_x = '0;
  logic signed [15:0] accel_y = '0;
  logic signed [15:0] accel_z = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [1:0] road_status;
  logic [15:0] pothole_total;
  logic [15:0] window_peak;
  logic [15:0] window_mean;

  road_roughness_classifier #(.WINDOW(WIN)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .road_status(road_status), .pothole_total(pothole_total),
    .window_peak(window_peak), .window_mean(window_mean)
  );

  // predictor state and configuration copy
  logic [15:0] base_lvl, hole_lvl, rough_lvl, hold_len;
  logic [15:0] dev_hist [WIN];
  int          wr_slot;
  logic [1:0]  cls;
  logic [15:0] hold_left, pothole_cnt, peak_seen, mean_seen;

  road_item_t   item_q[$];
  road_result_t road_due_q[$];
  road_item_t   nxt_item, got_item;
  road_result_t due;

  int  err_cnt = 0;
  int  checked = 0;
  int  queued_total = 0;
  int  phase_cnt = 0;
  int  kind_seen [4] = '{0, 0, 0, 0};
  int  cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_off_left = 0;
  bit  in_fire = 1'b0;
  bit  snd_idle = 1'b0;
  bit  rcv_idle = 1'b0;
  bit  hold_off_req = 1'b0;
  bit  hold_off_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [15:0] isqrt32(input logic [31:0] v);
    logic [15:0] r;
    logic [15:0] c;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      c = r | (16'd1 << b);
      if (32'(c) * 32'(c) <= v) r = c;
    end
    return r;
  endfunction

  function automatic road_result_t predict_road(input road_item_t it);
    longint       sx, sy, sz;
    logic [31:0]  energy, total;
    logic [15:0]  mag, dev, top;
    road_result_t r;
    case (it.kind)
      KIND_TICK: begin
        if (hold_left != 0) hold_left--;
      end
      KIND_SAMPLE: begin
        sx = longint'($signed(it.ax));
        sy = longint'($signed(it.ay));
        sz = longint'($signed(it.az));
        energy = 32'(sx * sx + sy * sy + sz * sz);
        mag = isqrt32(energy);
        dev = (mag >= base_lvl) ? mag - base_lvl : base_lvl - mag;
        dev_hist[wr_slot] = dev;
        wr_slot = (wr_slot == WIN - 1) ? 0 : wr_slot + 1;
        if (dev >= hole_lvl) begin
          // count only on entry into the pothole status
          if (cls != STATUS_POTHOLE && pothole_cnt != 16'hffff) pothole_cnt++;
          cls = STATUS_POTHOLE;
          hold_left = hold_len;
        end
      end
      KIND_EVAL: begin
        total = '0;
        top = '0;
        foreach (dev_hist[i]) begin
          if (dev_hist[i] > top) top = dev_hist[i];
          total += dev_hist[i];
        end
        peak_seen = top;
        mean_seen = 16'(total / WIN);
        if (hold_left != 0) cls = STATUS_POTHOLE;
        else if (total >= 32'(rough_lvl) * WIN) cls = STATUS_ROUGH;
        else cls = STATUS_NORMAL;
      end
      default: ;
    endcase
    r.status = cls;
    r.total = pothole_cnt;
    r.peak = peak_seen;
    r.mean = mean_seen;
    return r;
  endfunction

  // sender: present the next item at the falling edge, hold it until taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (item_q.size() != 0) begin
        nxt_item = item_q.pop_front();
        in_valid <= 1'b1;
        kind <= nxt_item.kind;
        accel_x <= nxt_item.ax;
        accel_y <= nxt_item.ay;
        accel_z <= nxt_item.az;
        if (snd_idle && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      stall_left <= 0;
      hold_off_left <= 0;
    end else if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_req && !hold_off_done) begin
      out_ready <= 1'b0;
      hold_off_left <= HOLD_OFF_CYCLES - 1;
      hold_off_done <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rcv_idle && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // predict on each input transaction, check each output transaction
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        got_item.kind = kind;
        got_item.ax = accel_x;
        got_item.ay = accel_y;
        got_item.az = accel_z;
        road_due_q.push_back(predict_road(got_item));
        kind_seen[int'(kind)]++;
      end
      if (out_valid && out_ready) begin
        if (road_due_q.size() == 0) begin
          $error("result transaction with nothing expected");
          err_cnt++;
        end else begin
          due = road_due_q.pop_front();
          checked++;
          if (road_status !== due.status) begin
            $error("road_status expected %0d got %0d", due.status, road_status);
            err_cnt++;
          end
          if (pothole_total !== due.total) begin
            $error("pothole_total expected %0d got %0d", due.total, pothole_total);
            err_cnt++;
          end
          if (window_peak !== due.peak) begin
            $error("window_peak expected %0d got %0d", due.peak, window_peak);
            err_cnt++;
          end
          if (window_mean !== due.mean) begin
            $error("window_mean expected %0d got %0d", due.mean, window_mean);
            err_cnt++;
          end
        end
      end
    end
  end

  task automatic add_item(input logic [1:0] k, input logic [15:0] x, y, z);
    road_item_t it;
    it.kind = k;
    it.ax = x;
    it.ay = y;
    it.az = z;
    item_q.push_back(it);
    queued_total++;
  endtask

  // sample whose magnitude lands near the configured baseline, or near 32767 when the baseline is higher
  task automatic add_near(input int spread);
    int zv, xv, yv;
    zv = (base_lvl > 16'd32767) ? 32767 : int'(base_lvl);
    zv = zv + int'($urandom_range(0, 2 * spread)) - spread;
    if ($urandom_range(0, 1) == 1) zv = -zv;
    if (zv > 32767) zv = 32767;
    if (zv < -32768) zv = -32768;
    xv = int'($urandom_range(0, spread / 2)) - spread / 4;
    yv = int'($urandom_range(0, spread / 2)) - spread / 4;
    add_item(KIND_SAMPLE, 16'(xv), 16'(yv), 16'(zv));
  endtask

  // road stretch: random items, or a window of samples with ticks, mostly then an evaluation
  task automatic add_segment();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(3, 8))
        add_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      for (int n = 0; n < WIN; n++) begin
        if (mode <= 4) add_near(150);
        else if (mode <= 7) add_near(2500);
        else if (n == 3) add_item(KIND_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom));
        else add_near(150);
        repeat ($urandom_range(0, 3)) add_item(KIND_TICK, '0, '0, '0);
      end
      // leave some windows unevaluated
      if ($urandom_range(0, 7) != 0) add_item(KIND_EVAL, '0, '0, '0);
    end
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_BASELINE: base_lvl = val;
      REG_POTHOLE:  hole_lvl = val;
      REG_ROUGH:    rough_lvl = val;
      REG_HOLD:     hold_len = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] b, h, r, t);
    write_reg(REG_BASELINE, b);
    write_reg(REG_POTHOLE, h);
    write_reg(REG_ROUGH, r);
    write_reg(REG_HOLD, t);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    while (item_q.size() != 0 || road_due_q.size() != 0 || in_valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] b, h, r, t, input bit s_idle, r_idle,
                           input int n_items, input bit with_hold_off);
    int start;
    set_config(b, h, r, t);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    if (with_hold_off) hold_off_req = 1'b1;
    start = queued_total;
    while (queued_total - start < n_items / 2) add_segment();
    // sender pause: drain everything before the second half
    wait_idle();
    while (queued_total - start < n_items) add_segment();
    wait_idle();
    phase_cnt++;
  endtask

  initial begin
    base_lvl = BASELINE_RST;
    hole_lvl = POTHOLE_RST;
    rough_lvl = ROUGH_RST;
    hold_len = HOLD_RST;
    foreach (dev_hist[i]) dev_hist[i] = '0;
    wr_slot = 0;
    cls = STATUS_NORMAL;
    hold_left = '0;
    pothole_cnt = '0;
    peak_seen = '0;
    mean_seen = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset configuration: empty ring, threshold edges, pothole entry and repeat
    add_item(KIND_EVAL, '0, '0, '0);
    add_item(2'd3, 16'h7fff, 16'h8000, 16'h0000);
    add_item(KIND_TICK, '0, '0, '0);
    add_item(KIND_SAMPLE, 16'd0, 16'd0, 16'd8192);
    add_item(KIND_SAMPLE, 16'd0, 16'd0, -16'sd8192);
    add_item(KIND_SAMPLE, 16'd0, 16'd0, 16'd9421);
    add_item(KIND_EVAL, '0, '0, '0);
    add_item(KIND_SAMPLE, 16'd0, 16'd0, 16'd13106);
    add_item(KIND_SAMPLE, 16'd0, 16'd0, 16'd13107);
    add_item(KIND_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
    add_item(KIND_TICK, '0, '0, '0);
    add_item(KIND_EVAL, '0, '0, '0);
    add_item(2'd3, 16'h0000, 16'h0000, 16'h0000);
    add_item(KIND_SAMPLE, 16'h7fff, 16'h7fff, 16'h7fff);
    add_item(KIND_SAMPLE, 16'd0, 16'd0, 16'd0);
    add_item(KIND_TICK, '0, '0, '0);
    wait_idle();

    // zero hold: pothole status lasts only until the next evaluation
    set_config(BASELINE_RST, POTHOLE_RST, ROUGH_RST, 16'd0);
    add_item(KIND_SAMPLE, 16'd0, 16'd0, 16'd0);
    add_item(KIND_EVAL, '0, '0, '0);
    add_item(KIND_SAMPLE, 16'd0, 16'd0, 16'd0);
    add_item(KIND_TICK, '0, '0, '0);
    add_item(KIND_EVAL, '0, '0, '0);
    add_item(2'd3, 16'hffff, 16'hffff, 16'hffff);
    wait_idle();

    run_phase(16'd8192, 16'd4915, 16'd1229, 16'd20, 1'b1, 1'b1, 160, 1'b1);
    run_phase(16'd0, 16'd65535, 16'd0, 16'd5, 1'b1, 1'b0, 160, 1'b0);
    run_phase(16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b0, 1'b1, 160, 1'b0);
    run_phase(16'd8192, 16'd0, 16'd1229, 16'd0, 1'b1, 1'b1, 160, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(0, 4000)),
              16'($urandom_range(0, 30)), 1'b1, 1'b1, 160, 1'b0);
    run_phase(16'd16384, 16'd2000, 16'd500, 16'd3, 1'b1, 1'b1, 160, 1'b0);
    run_phase(16'd4096, 16'd1500, 16'd200, 16'd1, 1'b1, 1'b1, 160, 1'b0);
    run_phase(16'd8192, 16'd4915, 16'd1229, 16'd10, 1'b0, 1'b0, 160, 1'b0);

    repeat (40) @(posedge clk);
    $display("Checked %0d results: %0d ticks, %0d samples, %0d evaluations, %0d unused kind",
             checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    $display("Ran %0d configuration phases; pothole count ended at %0d",
             phase_cnt, pothole_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rrc_pkg.sv
rtl/rrc_ram.sv
rtl/rrc_datapath.sv
rtl/rrc_ctrl.sv
rtl/road_roughness_classifier.sv
dv/tb.sv
